// ===== design/wted_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_pkg
// Shared types and constants of the write-then-execute dirty map.
// ----------------------------------------------------------------------------
package wted_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int START_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CMD_W       = 2;

    localparam int OFS_W       = 6;
    localparam int ROW_BITS    = 1 << OFS_W;
    localparam int ROW_IDX_W   = ADDR_BITS - OFS_W;
    localparam int ROWS        = 1 << ROW_IDX_W;
    localparam int LIM_W       = (ADDR_BITS + 1 > 18) ? ADDR_BITS + 1 : 18;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CMD_W-1:0]     CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0]     CMD_CLEAN = 2'd1;
    localparam logic [CMD_W-1:0]     CMD_EXEC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HIGH = 1'd1;

    typedef logic [ROW_IDX_W-1:0] row_idx_t;
    typedef logic [ROW_BITS-1:0]  row_data_t;
    typedef logic [OFS_W-1:0]     ofs_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_SET,
        OP_CLR,
        OP_EXEC
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [START_W-1:0] start_address;
        row_idx_t           first_row;
        row_idx_t           last_row;
        ofs_t               lo;
        ofs_t               hi_m1;
    } op_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_RESP
    } back_state_t;

endpackage
`default_nettype wire

// ===== design/wted_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_cmd_if
// Command channel: one request per write, clean or execute check.
// ----------------------------------------------------------------------------
interface wted_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [wted_pkg::CMD_W-1:0]   command;
    logic [wted_pkg::START_W-1:0] start_address;
    logic [wted_pkg::COUNT_W-1:0] byte_count;

    modport source (output valid, output command, output start_address,
                    output byte_count, input ready);
    modport sink   (input valid, input command, input start_address,
                    input byte_count, output ready);
endinterface
`default_nettype wire

// ===== design/wted_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_rsp_if
// Result channel: one response per command.
// ----------------------------------------------------------------------------
interface wted_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [wted_pkg::START_W-1:0] entry_address;

    modport source (output valid, output hit, output entry_address, input ready);
    modport sink   (input valid, input hit, input entry_address, output ready);
endinterface
`default_nettype wire

// ===== design/write_then_execute_dirty_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// write_then_execute_dirty_map
// Dirty bitmap with one bit per byte address; flags execution of written code.
// ----------------------------------------------------------------------------
// Requests arrive on cmd (write marks a range dirty, clean clears it, execute
// checks it) and each produces exactly one response on rsp (hit, entry_address).
// Region bounds must be written on the cfg port while no command is in flight;
// the block does not enforce this. The front end classifies a command in the
// cycle it is accepted and stores it in a two-entry queue. The back end walks
// the range 64 addresses per cycle through the bitmap RAM (read, then write
// back in the following cycle); a command that does nothing skips the walk
// and goes straight to the result register.
// A hit or a reset starts a clearing pass over all 1024 RAM rows, one row per
// cycle, before the next command is taken; cfg writes are taken throughout.
// The result register frees the back end only when rsp.ready takes it; while
// the receiver stalls, cmd keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module write_then_execute_dirty_map (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    wted_cmd_if.sink                            cmd,
    wted_rsp_if.source                          rsp,
    input  wire logic                           cfg_we,
    input  wire logic [wted_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wted_pkg::CFG_W-1:0]     cfg_wdata
);

    logic                q_full;
    logic                q_push;
    wted_pkg::op_t       q_entry;
    logic                q_pop;
    wted_pkg::op_t       q_head;
    logic                q_nonempty;
    logic                ram_we;
    wted_pkg::row_idx_t  ram_waddr;
    wted_pkg::row_data_t ram_wdata;
    logic                ram_re;
    wted_pkg::row_idx_t  ram_raddr;
    wted_pkg::row_data_t ram_rdata;

    wted_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    wted_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .nonempty   (q_nonempty)
    );

    wted_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .rsp        (rsp)
    );

    wted_ram #(
        .WIDTH (wted_pkg::ROW_BITS),
        .DEPTH (wted_pkg::ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== design/wted_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wted_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/wted_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_front
// Holds the region bounds, accepts commands and turns each into a row-range
// operation for the back end.
// ----------------------------------------------------------------------------
module wted_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    wted_cmd_if.sink                            cmd,
    input  wire logic                           cfg_we,
    input  wire logic [wted_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wted_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           q_full,
    output      logic                           q_push,
    output      wted_pkg::op_t                  q_entry
);

    localparam int LW = wted_pkg::LIM_W;
    localparam logic [LW-1:0] MAP_ADDRS = {{(LW-1){1'b0}}, 1'b1} << wted_pkg::ADDR_BITS;

    logic [wted_pkg::CFG_W-1:0] region_low_reg;
    logic [wted_pkg::CFG_W-1:0] region_high_reg;

    logic [LW-1:0]          start_ext;
    logic [LW-1:0]          sum;
    logic [LW-1:0]          limit;
    logic [LW-1:0]          last_addr;
    logic                   in_bounds;
    logic                   nonempty;
    wted_pkg::op_kind_t     kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_low_reg  <= '0;
            region_high_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wted_pkg::REG_REGION_LOW:  region_low_reg  <= cfg_wdata;
                wted_pkg::REG_REGION_HIGH: region_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        start_ext = LW'(cmd.start_address);
        sum       = start_ext + LW'(cmd.byte_count);
        limit     = (sum > MAP_ADDRS) ? MAP_ADDRS : sum;
        last_addr = limit - LW'(1);
        nonempty  = start_ext < limit;
        in_bounds = (cmd.start_address > region_low_reg)
                 && (cmd.start_address < region_high_reg);
        unique case (cmd.command)
            wted_pkg::CMD_WRITE: kind = wted_pkg::OP_SET;
            wted_pkg::CMD_CLEAN: kind = wted_pkg::OP_CLR;
            wted_pkg::CMD_EXEC:  kind = wted_pkg::OP_EXEC;
            default:             kind = wted_pkg::OP_NOP;
        endcase
        if (!(in_bounds && nonempty))
        begin
            kind = wted_pkg::OP_NOP;
        end
    end

    assign cmd.ready             = !q_full;
    assign q_push                = cmd.valid && !q_full;
    assign q_entry.kind          = kind;
    assign q_entry.start_address = cmd.start_address;
    assign q_entry.first_row     = start_ext[wted_pkg::ADDR_BITS-1:wted_pkg::OFS_W];
    assign q_entry.last_row      = last_addr[wted_pkg::ADDR_BITS-1:wted_pkg::OFS_W];
    assign q_entry.lo            = start_ext[wted_pkg::OFS_W-1:0];
    assign q_entry.hi_m1         = last_addr[wted_pkg::OFS_W-1:0];

endmodule
`default_nettype wire

// ===== design/wted_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_queue
// Short operation queue between front and back end.
// ----------------------------------------------------------------------------
module wted_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire wted_pkg::op_t push_entry,
    output      logic          full,
    input  wire logic          pop,
    output      wted_pkg::op_t head,
    output      logic          nonempty
);

    wted_pkg::op_t               entry_reg [wted_pkg::QUEUE_DEPTH];
    logic [wted_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [wted_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [wted_pkg::QPTR_W:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full     = count_reg == (wted_pkg::QPTR_W+1)'(wted_pkg::QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign head     = entry_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ===== design/wted_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wted_back
// Walks each operation's rows through the bitmap RAM (read-modify-write for set
// and clear, read-only for execute), clears the map after reset and after a hit,
// and holds the result register.
module wted_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_nonempty,
    input  wire wted_pkg::op_t       q_head,
    output      logic                q_pop,
    output      logic                ram_we,
    output      wted_pkg::row_idx_t  ram_waddr,
    output      wted_pkg::row_data_t ram_wdata,
    output      logic                ram_re,
    output      wted_pkg::row_idx_t  ram_raddr,
    input  wire wted_pkg::row_data_t ram_rdata,
    wted_rsp_if.source               rsp
);

    wted_pkg::back_state_t state_reg, state_next;
    wted_pkg::op_t         op_reg, op_next;
    wted_pkg::row_idx_t    row_reg, row_next;
    wted_pkg::row_idx_t    clr_row_reg, clr_row_next;
    wted_pkg::row_idx_t    pend_row_reg, pend_row_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  pend_first_reg, pend_first_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  hit_reg, hit_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic [wted_pkg::START_W-1:0] out_addr_reg, out_addr_next;

    wted_pkg::ofs_t        lo;
    wted_pkg::ofs_t        hi;
    wted_pkg::row_data_t   mask;
    logic                  hit_now;
    logic                  out_free;

    always_comb
    begin
        lo       = pend_first_reg ? op_reg.lo : '0;
        hi       = pend_last_reg ? op_reg.hi_m1 : '1;
        mask     = ({wted_pkg::ROW_BITS{1'b1}} << lo) & ({wted_pkg::ROW_BITS{1'b1}} >> ~hi);
        hit_now  = pend_valid_reg && (op_reg.kind == wted_pkg::OP_EXEC)
                && ((ram_rdata & mask) != '0);
        out_free = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wted_pkg::BK_CLEAR:
            begin
                if (&clr_row_reg)
                begin
                    state_next = hit_reg ? wted_pkg::BK_RESP : wted_pkg::BK_IDLE;
                end
            end
            wted_pkg::BK_IDLE:
            begin
                if (q_nonempty)
                begin
                    state_next = (q_head.kind == wted_pkg::OP_NOP)
                               ? wted_pkg::BK_RESP : wted_pkg::BK_SCAN;
                end
            end
            wted_pkg::BK_SCAN:
            begin
                if (hit_now)
                begin
                    state_next = wted_pkg::BK_CLEAR;
                end
                else if (row_reg == op_reg.last_row)
                begin
                    state_next = wted_pkg::BK_DRAIN;
                end
            end
            wted_pkg::BK_DRAIN:
            begin
                state_next = hit_now ? wted_pkg::BK_CLEAR : wted_pkg::BK_RESP;
            end
            wted_pkg::BK_RESP:
            begin
                if (out_free)
                begin
                    state_next = wted_pkg::BK_IDLE;
                end
            end
            default: state_next = wted_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        row_next        = row_reg;
        clr_row_next    = clr_row_reg;
        pend_row_next   = row_reg;
        pend_valid_next = 1'b0;
        pend_first_next = row_reg == op_reg.first_row;
        pend_last_next  = row_reg == op_reg.last_row;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hit_next    = out_hit_reg;
        out_addr_next   = out_addr_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = pend_row_reg;
        ram_wdata       = ram_rdata | mask;
        ram_re          = 1'b0;
        ram_raddr       = row_reg;

        if (pend_valid_reg)
        begin
            case (op_reg.kind)
                wted_pkg::OP_SET:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | mask;
                end
                wted_pkg::OP_CLR:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~mask;
                end
                default: ;
            endcase
        end

        if (hit_now)
        begin
            hit_next     = 1'b1;
            clr_row_next = '0;
        end

        unique case (state_reg)
            wted_pkg::BK_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_row_reg;
                ram_wdata    = '0;
                clr_row_next = clr_row_reg + 1'b1;
            end
            wted_pkg::BK_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_head;
                    row_next = q_head.first_row;
                    hit_next = 1'b0;
                end
            end
            wted_pkg::BK_SCAN:
            begin
                ram_re          = 1'b1;
                pend_valid_next = !hit_now;
                row_next        = row_reg + 1'b1;
            end
            wted_pkg::BK_DRAIN: ;
            wted_pkg::BK_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_addr_next  = hit_reg ? op_reg.start_address : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wted_pkg::BK_CLEAR;
            clr_row_reg    <= '0;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            pend_valid_reg <= pend_valid_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        row_reg        <= row_next;
        pend_row_reg   <= pend_row_next;
        pend_first_reg <= pend_first_next;
        pend_last_reg  <= pend_last_next;
        out_hit_reg    <= out_hit_next;
        out_addr_reg   <= out_addr_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.entry_address = out_addr_reg;

`ifndef SYNTHESIS
    a_no_same_row_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bitmap row read and written in the same cycle");

    a_pend_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(state_reg == wted_pkg::BK_SCAN))
        else $error("pending row without a scan read");

    a_scan_real_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wted_pkg::BK_SCAN) |-> (op_reg.kind != wted_pkg::OP_NOP))
        else $error("scan started for an empty operation");

    a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wted_pkg::BK_CLEAR && state_next != wted_pkg::BK_CLEAR)
        |-> (&clr_row_reg))
        else $error("clear pass left early");

    a_hit_result_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wted_pkg::BK_RESP && hit_reg) |-> $past(state_reg == wted_pkg::BK_CLEAR)
        || $past(state_reg == wted_pkg::BK_RESP))
        else $error("hit reported without clearing the map");
`endif

endmodule
`default_nettype wire
